// File: src/mka_pkg.sv
// Shared types, codes and defaults for the mouse keys accelerator.
package mka_pkg;

	localparam int unsigned WHEEL_DIVIDE_BITS = 4;
	localparam int unsigned CFG_ADDR_W = 4;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_START_DELAY = 2'd0;
	localparam logic [1:0] REG_REPEAT_INTV = 2'd1;
	localparam logic [1:0] REG_SPEEDUP     = 2'd2;
	localparam logic [1:0] REG_SPEED_CAP   = 2'd3;

	localparam logic [7:0] START_DELAY_RST = 8'd40;
	localparam logic [7:0] REPEAT_INTV_RST = 8'd5;
	localparam logic [7:0] SPEEDUP_RST     = 8'd10;
	localparam logic [6:0] SPEED_CAP_RST   = 7'd20;

	// Key codes
	localparam logic [7:0] KEY_FIRST   = 8'hF0;
	localparam logic [7:0] KEY_UP      = 8'hF0;
	localparam logic [7:0] KEY_DOWN    = 8'hF1;
	localparam logic [7:0] KEY_LEFT    = 8'hF2;
	localparam logic [7:0] KEY_RIGHT   = 8'hF3;
	localparam logic [7:0] KEY_BTN1    = 8'hF4;
	localparam logic [7:0] KEY_BTN5    = 8'hF8;
	localparam logic [7:0] KEY_WH_UP   = 8'hF9;
	localparam logic [7:0] KEY_WH_DOWN = 8'hFA;
	localparam logic [7:0] KEY_WH_LEFT = 8'hFB;
	localparam logic [7:0] KEY_WH_RGHT = 8'hFC;
	localparam logic [7:0] KEY_ACC0    = 8'hFD;
	localparam logic [7:0] KEY_ACC2    = 8'hFF;

	// Axis slots
	localparam int unsigned AX_X = 0;
	localparam int unsigned AX_Y = 1;
	localparam int unsigned AX_V = 2;
	localparam int unsigned AX_H = 3;

	// Repeat phase at which reports go out
	localparam logic [1:0] PHASE_RUN = 2'd2;

	typedef struct packed {
		logic [7:0] start_delay_ms;
		logic [7:0] repeat_interval_ms;
		logic [7:0] speedup_period;
		logic [6:0] speed_cap;
	} cfg_t;

	typedef struct packed {
		logic [4:0]        buttons;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic signed [7:0] wheel_v;
		logic signed [7:0] wheel_h;
	} report_t;

endpackage

// File: src/mka_channels.sv
// Valid/ready channel interfaces for key items and mouse reports.
interface mka_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] key_code;

	modport source (output valid, output operation, output key_code, input ready);
	modport sink (input valid, input operation, input key_code, output ready);
endinterface

interface mka_report_if;
	logic              valid;
	logic              ready;
	logic [4:0]        buttons;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic signed [7:0] wheel_v;
	logic signed [7:0] wheel_h;

	modport source (output valid, output buttons, output move_x, output move_y,
		output wheel_v, output wheel_h, input ready);
	modport sink (input valid, input buttons, input move_x, input move_y,
		input wheel_v, input wheel_h, output ready);
endinterface

// File: src/mka_cfg_regs.sv
// APB register file holding the four timing and speed settings.
module mka_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mka_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output mka_pkg::cfg_t                     cfg
);

	mka_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay_ms     <= mka_pkg::START_DELAY_RST;
			cfg_q.repeat_interval_ms <= mka_pkg::REPEAT_INTV_RST;
			cfg_q.speedup_period     <= mka_pkg::SPEEDUP_RST;
			cfg_q.speed_cap          <= mka_pkg::SPEED_CAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				mka_pkg::REG_START_DELAY: cfg_q.start_delay_ms <= pwdata[7:0];
				mka_pkg::REG_REPEAT_INTV: cfg_q.repeat_interval_ms <= pwdata[7:0];
				mka_pkg::REG_SPEEDUP:     cfg_q.speedup_period <= pwdata[7:0];
				mka_pkg::REG_SPEED_CAP:   cfg_q.speed_cap <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mka_pkg::REG_START_DELAY: prdata = {24'd0, cfg_q.start_delay_ms};
			mka_pkg::REG_REPEAT_INTV: prdata = {24'd0, cfg_q.repeat_interval_ms};
			mka_pkg::REG_SPEEDUP:     prdata = {24'd0, cfg_q.speedup_period};
			mka_pkg::REG_SPEED_CAP:   prdata = {25'd0, cfg_q.speed_cap};
			default:                  prdata = '0;
		endcase
	end

endmodule

// File: src/mka_core.sv
// Key state, repeat timing and speed ramp; updates once per processed item.
module mka_core #(
	parameter int unsigned WheelBits = mka_pkg::WHEEL_DIVIDE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mka_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic [1:0]        op,
	input  logic [7:0]        key,
	output logic              fire,
	output mka_pkg::report_t  rpt
);

	logic [4:0]           btn_q, btn_d;
	logic signed [7:0]    axis_q [4];
	logic signed [7:0]    axis_d [4];
	logic [2:0]           acc_q, acc_d;
	logic [1:0]           phase_q, phase_d;
	logic [WheelBits-1:0] wcnt_q, wcnt_d;
	logic [7:0]           spd_q, spd_d;
	logic [15:0]          ms_q, ms_d;

	logic [15:0]          ms_inc;
	logic [7:0]           wait_ms;
	logic                 any_axis;
	logic [7:0]           spd_inc;
	logic [WheelBits-1:0] wcnt_inc;
	logic                 wheel_now;
	logic [2:0]           btn_idx;
	logic [1:0]           acc_idx;

	// One speed step for one axis
	function automatic logic signed [7:0] ramp(
		input logic signed [7:0] v,
		input logic [6:0]        m,
		input logic [2:0]        acc
	);
		logic [7:0]        c;
		logic signed [7:0] cs;
		logic signed [8:0] ms;
		logic signed [8:0] up;
		logic signed [8:0] dn;
		logic signed [7:0] res;
		c  = 8'(m[6:2]) * 8'(acc);
		cs = (c > 8'd127) ? 8'sd127 : signed'(c);
		ms = signed'({2'b00, m});
		up = {v[7], v} + 9'sd1;
		dn = {v[7], v} - 9'sd1;
		if (v == 8'sd0) begin
			res = 8'sd0;
		end else if (acc != 3'd0) begin
			res = (v > 8'sd0) ? cs : -cs;
		end else if (v > 8'sd0) begin
			res = (up > ms) ? signed'({1'b0, m}) : up[7:0];
		end else begin
			res = (dn < -ms) ? -signed'({1'b0, m}) : dn[7:0];
		end
		return res;
	endfunction

	assign ms_inc    = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
	assign wait_ms   = (phase_q == mka_pkg::PHASE_RUN) ? cfg.repeat_interval_ms
		: cfg.start_delay_ms;
	assign any_axis  = (axis_q[0] != 8'sd0) || (axis_q[1] != 8'sd0)
		|| (axis_q[2] != 8'sd0) || (axis_q[3] != 8'sd0);
	assign spd_inc   = spd_q + 8'd1;
	assign wcnt_inc  = wcnt_q + WheelBits'(1);
	assign wheel_now = (wcnt_inc == '0);
	assign btn_idx   = 3'(key - mka_pkg::KEY_BTN1);
	assign acc_idx   = 2'(key - mka_pkg::KEY_ACC0);

	always_comb begin
		btn_d   = btn_q;
		axis_d  = axis_q;
		acc_d   = acc_q;
		phase_d = phase_q;
		wcnt_d  = wcnt_q;
		spd_d   = spd_q;
		ms_d    = ms_q;
		fire    = 1'b0;

		rpt.buttons = btn_q;
		rpt.move_x  = axis_q[mka_pkg::AX_X];
		rpt.move_y  = axis_q[mka_pkg::AX_Y];
		rpt.wheel_v = wheel_now ? axis_q[mka_pkg::AX_V] : 8'sd0;
		rpt.wheel_h = wheel_now ? axis_q[mka_pkg::AX_H] : 8'sd0;

		unique case (mka_pkg::op_t'(op))
			mka_pkg::OP_PRESS: begin
				unique case (key) inside
					mka_pkg::KEY_UP:      axis_d[mka_pkg::AX_Y] = -8'sd1;
					mka_pkg::KEY_DOWN:    axis_d[mka_pkg::AX_Y] = 8'sd1;
					mka_pkg::KEY_LEFT:    axis_d[mka_pkg::AX_X] = -8'sd1;
					mka_pkg::KEY_RIGHT:   axis_d[mka_pkg::AX_X] = 8'sd1;
					[mka_pkg::KEY_BTN1:mka_pkg::KEY_BTN5]:
						btn_d = btn_q | (5'd1 << btn_idx);
					mka_pkg::KEY_WH_UP: begin
						axis_d[mka_pkg::AX_V] = 8'sd1;
						wcnt_d = '0;
					end
					mka_pkg::KEY_WH_DOWN: begin
						axis_d[mka_pkg::AX_V] = -8'sd1;
						wcnt_d = '0;
					end
					mka_pkg::KEY_WH_LEFT: begin
						axis_d[mka_pkg::AX_H] = -8'sd1;
						wcnt_d = '0;
					end
					mka_pkg::KEY_WH_RGHT: begin
						axis_d[mka_pkg::AX_H] = 8'sd1;
						wcnt_d = '0;
					end
					[mka_pkg::KEY_ACC0:mka_pkg::KEY_ACC2]:
						acc_d = acc_q | (3'd1 << acc_idx);
					default: ;
				endcase
			end
			mka_pkg::OP_RELEASE: begin
				// drop an axis only when it points the released way
				unique case (key) inside
					mka_pkg::KEY_UP:
						if (axis_q[mka_pkg::AX_Y] < 8'sd0) axis_d[mka_pkg::AX_Y] = 8'sd0;
					mka_pkg::KEY_DOWN:
						if (axis_q[mka_pkg::AX_Y] > 8'sd0) axis_d[mka_pkg::AX_Y] = 8'sd0;
					mka_pkg::KEY_LEFT:
						if (axis_q[mka_pkg::AX_X] < 8'sd0) axis_d[mka_pkg::AX_X] = 8'sd0;
					mka_pkg::KEY_RIGHT:
						if (axis_q[mka_pkg::AX_X] > 8'sd0) axis_d[mka_pkg::AX_X] = 8'sd0;
					[mka_pkg::KEY_BTN1:mka_pkg::KEY_BTN5]:
						btn_d = btn_q & ~(5'd1 << btn_idx);
					mka_pkg::KEY_WH_UP:
						if (axis_q[mka_pkg::AX_V] > 8'sd0) axis_d[mka_pkg::AX_V] = 8'sd0;
					mka_pkg::KEY_WH_DOWN:
						if (axis_q[mka_pkg::AX_V] < 8'sd0) axis_d[mka_pkg::AX_V] = 8'sd0;
					mka_pkg::KEY_WH_LEFT:
						if (axis_q[mka_pkg::AX_H] < 8'sd0) axis_d[mka_pkg::AX_H] = 8'sd0;
					mka_pkg::KEY_WH_RGHT:
						if (axis_q[mka_pkg::AX_H] > 8'sd0) axis_d[mka_pkg::AX_H] = 8'sd0;
					[mka_pkg::KEY_ACC0:mka_pkg::KEY_ACC2]:
						acc_d = acc_q & ~(3'd1 << acc_idx);
					default: ;
				endcase
			end
			mka_pkg::OP_CLEAR: begin
				btn_d = '0;
				acc_d = '0;
				for (int i = 0; i < 4; i++) begin
					axis_d[i] = 8'sd0;
				end
			end
			mka_pkg::OP_TICK: begin
				ms_d = ms_inc;
				if (ms_inc < {8'd0, wait_ms}) begin
					// hold: delay not yet elapsed
				end else if (!any_axis) begin
					phase_d = '0;
				end else if (phase_q != mka_pkg::PHASE_RUN) begin
					phase_d = phase_q + 2'd1;
				end else begin
					fire   = 1'b1;
					wcnt_d = wcnt_inc;
					ms_d   = '0;
					spd_d  = spd_inc;
					if (spd_inc > cfg.speedup_period) begin
						spd_d = '0;
						for (int i = 0; i < 4; i++) begin
							axis_d[i] = ramp(axis_q[i], cfg.speed_cap, acc_q);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q   <= '0;
			acc_q   <= '0;
			phase_q <= '0;
			wcnt_q  <= '0;
			spd_q   <= '0;
			ms_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				axis_q[i] <= 8'sd0;
			end
		end else if (step) begin
			btn_q   <= btn_d;
			acc_q   <= acc_d;
			phase_q <= phase_d;
			wcnt_q  <= wcnt_d;
			spd_q   <= spd_d;
			ms_q    <= ms_d;
			axis_q  <= axis_d;
		end
	end

endmodule

// File: src/mouse_keys_accelerator.sv
// Top level: input register, accelerator state and registered report output.
//
//  channel   dir   handshake       payload
//  item      in    valid/ready     operation[1:0], key_code[7:0]
//  report    out   valid/ready     buttons[4:0], move_x, move_y, wheel_v, wheel_h
//  apb       in    psel/penable    paddr[3:0], pwdata, prdata (pready tied high)
//
// One item per cycle while the report register is not stalled.
// The item register feeds the state update, which loads the report register.
// A stalled report holds the item register; item.ready drops then and in the
// first cycle after reset.
// Reset clears control/core state, loads register defaults; no clearing pass.
module mouse_keys_accelerator #(
	parameter int unsigned WHEEL_DIVIDE_BITS = mka_pkg::WHEEL_DIVIDE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mka_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	mka_item_if.sink                       item,
	mka_report_if.source                   report
);

	mka_pkg::cfg_t    cfg;
	mka_pkg::report_t rpt;
	mka_pkg::report_t rpt_q;
	logic             fire;
	logic             live_q;
	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       key_s1;
	logic             out_valid_q;
	logic             adv;
	logic             step;

	mka_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mka_core #(
		.WheelBits (WHEEL_DIVIDE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.op     (op_s1),
		.key    (key_s1),
		.fire   (fire),
		.rpt    (rpt)
	);

	// advance when the report register is free or being drained
	assign adv        = !out_valid_q || report.ready;
	assign step       = valid_s1 && adv;
	assign item.ready = live_q && (!valid_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				out_valid_q <= step && fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1  <= item.operation;
			key_s1 <= item.key_code;
		end
		if (step && fire) begin
			rpt_q <= rpt;
		end
	end

	assign report.valid   = out_valid_q;
	assign report.buttons = rpt_q.buttons;
	assign report.move_x  = rpt_q.move_x;
	assign report.move_y  = rpt_q.move_y;
	assign report.wheel_v = rpt_q.wheel_v;
	assign report.wheel_h = rpt_q.wheel_h;

endmodule

// File: src/mka_checker.sv
// Port-level checks for the mouse keys accelerator, bound to the top level.
module mka_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        in_op,
	input logic              out_valid,
	input logic              out_ready,
	input logic [4:0]        out_buttons,
	input logic signed [7:0] out_x,
	input logic signed [7:0] out_y,
	input logic signed [7:0] out_v,
	input logic signed [7:0] out_h
);

	// a held report beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("report beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_buttons, out_x, out_y, out_v, out_h}))
		else $error("report payload changed while stalled");

	// a fresh report must follow an accepted tick beat
	a_rose_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
		$past(in_valid && in_ready && in_op == mka_pkg::OP_TICK, 2))
		else $error("report without a preceding tick");

	// axis values are saturated to +/-127
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_x != -8'sd128 && out_y != -8'sd128
		&& out_v != -8'sd128 && out_h != -8'sd128)
		else $error("report axis out of range");

endmodule

bind mouse_keys_accelerator mka_checker u_mka_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_op       (item.operation),
	.out_valid   (report.valid),
	.out_ready   (report.ready),
	.out_buttons (report.buttons),
	.out_x       (report.move_x),
	.out_y       (report.move_y),
	.out_v       (report.wheel_v),
	.out_h       (report.wheel_h)
);

// File: test/mouse_keys_accelerator_tb.sv
// Self-checking testbench for the mouse keys accelerator: random key/tick stream, report scoreboard.
`timescale 1ns / 100ps

module mouse_keys_accelerator_tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	class mouse_report_board;
		mka_pkg::cfg_t                         cfg;
		logic [4:0]                            button_bits;
		int                                    axis[4];
		logic [2:0]                            accel_bits;
		logic [1:0]                            phase;
		logic [mka_pkg::WHEEL_DIVIDE_BITS-1:0] wheel_count;
		logic [7:0]                            speedup_count;
		logic [15:0]                           ms_count;
		mka_pkg::report_t                      pending_reports[$];
		int                                    failures;
		int                                    beats;
		int                                    reports;
		int                                    wheel_reports;

		function new();
			cfg.start_delay_ms     = mka_pkg::START_DELAY_RST;
			cfg.repeat_interval_ms = mka_pkg::REPEAT_INTV_RST;
			cfg.speedup_period     = mka_pkg::SPEEDUP_RST;
			cfg.speed_cap          = mka_pkg::SPEED_CAP_RST;
			button_bits   = '0;
			foreach (axis[i]) axis[i] = 0;
			accel_bits    = '0;
			phase         = '0;
			wheel_count   = '0;
			speedup_count = '0;
			ms_count      = '0;
			failures      = 0;
			beats         = 0;
			reports       = 0;
			wheel_reports = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				mka_pkg::REG_START_DELAY: cfg.start_delay_ms = val;
				mka_pkg::REG_REPEAT_INTV: cfg.repeat_interval_ms = val;
				mka_pkg::REG_SPEEDUP:     cfg.speedup_period = val;
				mka_pkg::REG_SPEED_CAP:   cfg.speed_cap = val[6:0];
				default: ;
			endcase
		endfunction

		function void log_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		function void apply_item(mka_pkg::op_t op, logic [7:0] k);
			int               m;
			int               c;
			int               v;
			logic [7:0]       delay;
			mka_pkg::report_t rep;
			beats++;
			case (op)
				mka_pkg::OP_PRESS: if (k >= mka_pkg::KEY_FIRST) begin
					if (k == mka_pkg::KEY_UP) axis[mka_pkg::AX_Y] = -1;
					else if (k == mka_pkg::KEY_DOWN) axis[mka_pkg::AX_Y] = 1;
					else if (k == mka_pkg::KEY_LEFT) axis[mka_pkg::AX_X] = -1;
					else if (k == mka_pkg::KEY_RIGHT) axis[mka_pkg::AX_X] = 1;
					else if (k <= mka_pkg::KEY_BTN5)
						button_bits |= 5'(1 << (k - mka_pkg::KEY_BTN1));
					else if (k == mka_pkg::KEY_WH_UP) axis[mka_pkg::AX_V] = 1;
					else if (k == mka_pkg::KEY_WH_DOWN) axis[mka_pkg::AX_V] = -1;
					else if (k == mka_pkg::KEY_WH_LEFT) axis[mka_pkg::AX_H] = -1;
					else if (k == mka_pkg::KEY_WH_RGHT) axis[mka_pkg::AX_H] = 1;
					else accel_bits |= 3'(1 << (k - mka_pkg::KEY_ACC0));
					if (k >= mka_pkg::KEY_WH_UP && k <= mka_pkg::KEY_WH_RGHT)
						wheel_count = '0;
				end
				mka_pkg::OP_RELEASE: if (k >= mka_pkg::KEY_FIRST) begin
					// an axis only drops when it points the released way
					if (k == mka_pkg::KEY_UP) begin
						if (axis[mka_pkg::AX_Y] < 0) axis[mka_pkg::AX_Y] = 0;
					end else if (k == mka_pkg::KEY_DOWN) begin
						if (axis[mka_pkg::AX_Y] > 0) axis[mka_pkg::AX_Y] = 0;
					end else if (k == mka_pkg::KEY_LEFT) begin
						if (axis[mka_pkg::AX_X] < 0) axis[mka_pkg::AX_X] = 0;
					end else if (k == mka_pkg::KEY_RIGHT) begin
						if (axis[mka_pkg::AX_X] > 0) axis[mka_pkg::AX_X] = 0;
					end else if (k <= mka_pkg::KEY_BTN5) begin
						button_bits &= ~5'(1 << (k - mka_pkg::KEY_BTN1));
					end else if (k == mka_pkg::KEY_WH_UP) begin
						if (axis[mka_pkg::AX_V] > 0) axis[mka_pkg::AX_V] = 0;
					end else if (k == mka_pkg::KEY_WH_DOWN) begin
						if (axis[mka_pkg::AX_V] < 0) axis[mka_pkg::AX_V] = 0;
					end else if (k == mka_pkg::KEY_WH_LEFT) begin
						if (axis[mka_pkg::AX_H] < 0) axis[mka_pkg::AX_H] = 0;
					end else if (k == mka_pkg::KEY_WH_RGHT) begin
						if (axis[mka_pkg::AX_H] > 0) axis[mka_pkg::AX_H] = 0;
					end else begin
						accel_bits &= ~3'(1 << (k - mka_pkg::KEY_ACC0));
					end
				end
				mka_pkg::OP_CLEAR: begin
					button_bits = '0;
					foreach (axis[i]) axis[i] = 0;
					accel_bits = '0;
				end
				default: begin
					if (ms_count != 16'hFFFF)
						ms_count++;
					delay = (phase == mka_pkg::PHASE_RUN) ? cfg.repeat_interval_ms
						: cfg.start_delay_ms;
					if (ms_count < delay)
						return;
					if ((axis[mka_pkg::AX_X] | axis[mka_pkg::AX_Y] | axis[mka_pkg::AX_V]
							| axis[mka_pkg::AX_H]) == 0) begin
						phase = '0;
						return;
					end
					if (phase < mka_pkg::PHASE_RUN) begin
						phase++;
						return;
					end
					wheel_count++;
					rep.buttons = button_bits;
					rep.move_x  = 8'(axis[mka_pkg::AX_X]);
					rep.move_y  = 8'(axis[mka_pkg::AX_Y]);
					rep.wheel_v = (wheel_count == 0) ? 8'(axis[mka_pkg::AX_V]) : 8'sd0;
					rep.wheel_h = (wheel_count == 0) ? 8'(axis[mka_pkg::AX_H]) : 8'sd0;
					pending_reports.push_back(rep);
					ms_count = '0;
					speedup_count++;
					if (speedup_count > cfg.speedup_period) begin
						speedup_count = '0;
						m = cfg.speed_cap;
						c = (m / 4) * int'(accel_bits);
						foreach (axis[i]) begin
							if (axis[i] != 0) begin
								if (accel_bits != 0) v = (axis[i] > 0) ? c : -c;
								else if (axis[i] > 0) v = (axis[i] + 1 > m) ? m : axis[i] + 1;
								else v = (axis[i] - 1 < -m) ? -m : axis[i] - 1;
								axis[i] = (v > 127) ? 127 : (v < -127) ? -127 : v;
							end
						end
					end
				end
			endcase
		endfunction

		function void compare_report(mka_pkg::report_t got);
			mka_pkg::report_t want;
			if (pending_reports.size() == 0) begin
				log_failure($sformatf("report with none due: b=%0h x=%0d y=%0d v=%0d h=%0d",
					got.buttons, got.move_x, got.move_y, got.wheel_v, got.wheel_h));
				return;
			end
			want = pending_reports.pop_front();
			reports++;
			if (want.wheel_v != 0 || want.wheel_h != 0)
				wheel_reports++;
			if (got.buttons !== want.buttons || got.move_x !== want.move_x ||
					got.move_y !== want.move_y || got.wheel_v !== want.wheel_v ||
					got.wheel_h !== want.wheel_h)
				log_failure($sformatf({"want b=%0h x=%0d y=%0d v=%0d h=%0d,",
					" got b=%0h x=%0d y=%0d v=%0d h=%0d"},
					want.buttons, want.move_x, want.move_y, want.wheel_v, want.wheel_h,
					got.buttons, got.move_x, got.move_y, got.wheel_v, got.wheel_h));
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mka_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;

	mka_item_if   item_ch ();
	mka_report_if report_ch ();

	mouse_report_board board;
	bit                idle_on = 1'b1;
	bit                hold_req = 1'b0;
	int                quiet_cycles = 0;

	mouse_keys_accelerator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.report  (report_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(1'b1, idx, {24'd0, val}, rd);
		board.set_reg(idx, val);
		want = (idx == mka_pkg::REG_SPEED_CAP) ? {25'd0, val[6:0]} : {24'd0, val};
		apb_access(1'b0, idx, '0, rd);
		if (rd !== want)
			board.log_failure($sformatf("register %0d reads %0h, want %0h", idx, rd, want));
	endtask

	task automatic configure(input logic [7:0] start, input logic [7:0] rpt,
			input logic [7:0] spd, input logic [6:0] top_speed);
		write_reg(mka_pkg::REG_START_DELAY, start);
		write_reg(mka_pkg::REG_REPEAT_INTV, rpt);
		write_reg(mka_pkg::REG_SPEEDUP, spd);
		write_reg(mka_pkg::REG_SPEED_CAP, {1'b0, top_speed});
	endtask

	task automatic put_item(input mka_pkg::op_t op, input logic [7:0] code);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.key_code  <= code;
		@(negedge clk);
		while (!item_ch.ready) @(negedge clk);
		@(posedge clk);
		board.apply_item(op, code);
	endtask

	// drop valid, drain every report due, then let the pipeline go quiet
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (board.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] start, input logic [7:0] rpt,
			input logic [7:0] spd, input logic [6:0] top_speed, input int n_items,
			input bit idling, input bit squeeze);
		int         sent;
		int         nt;
		int         r;
		logic [7:0] code;
		configure(start, rpt, spd, top_speed);
		idle_on = idling;
		if (squeeze)
			hold_req = 1'b1;
		sent = 0;
		while (sent < n_items) begin
			// a few key events, then a run of ticks
			repeat ($urandom_range(0, 3)) begin
				r = $urandom_range(0, 99);
				code = mka_pkg::KEY_FIRST + 8'($urandom_range(0, 15));
				if (r < 60) begin
					put_item(mka_pkg::OP_PRESS, code);
				end else if (r < 80) begin
					put_item(mka_pkg::OP_RELEASE, code);
				end else if (r < 95) begin
					code = 8'($urandom);
					if ($urandom_range(0, 1)) put_item(mka_pkg::OP_PRESS, code);
					else put_item(mka_pkg::OP_RELEASE, code);
					if (code < mka_pkg::KEY_FIRST)
						sent--;
				end else begin
					put_item(mka_pkg::OP_CLEAR, 8'($urandom));
				end
				sent++;
			end
			nt = $urandom_range(1, 60);
			repeat (nt) put_item(mka_pkg::OP_TICK, 8'($urandom));
			sent += nt;
		end
		settle();
	endtask

	// report sink: random stall bursts while idle_on is set, one long hold on request
	initial begin
		report_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				report_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				report_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				report_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(negedge clk) begin
		mka_pkg::report_t got;
		if (report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
			got.buttons = report_ch.buttons;
			got.move_x  = report_ch.move_x;
			got.move_y  = report_ch.move_y;
			got.wheel_v = report_ch.wheel_v;
			got.wheel_h = report_ch.wheel_h;
			board.compare_report(got);
		end
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(report_ch.valid === 1'b1 && report_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		item_ch.valid     <= 1'b0;
		item_ch.operation <= mka_pkg::OP_TICK;
		item_ch.key_code  <= 8'h00;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every tick counts, each report steps speed
		idle_on = 1'b0;
		configure(8'd0, 8'd0, 8'd0, 7'd127);
		put_item(mka_pkg::OP_PRESS, 8'h00);
		put_item(mka_pkg::OP_PRESS, 8'hEF);
		put_item(mka_pkg::OP_RELEASE, 8'h7F);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_BTN1);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_BTN5);
		put_item(mka_pkg::OP_TICK, 8'hFF);
		put_item(mka_pkg::OP_TICK, 8'h00);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_LEFT);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_WH_UP);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_ACC0);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_ACC2);
		repeat (4) put_item(mka_pkg::OP_TICK, 8'h00);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_RIGHT);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_ACC0);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_ACC2);
		put_item(mka_pkg::OP_TICK, 8'h00);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_LEFT);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_WH_UP);
		put_item(mka_pkg::OP_RELEASE, mka_pkg::KEY_BTN5);
		put_item(mka_pkg::OP_TICK, 8'h00);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_UP);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_WH_LEFT);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_WH_RGHT);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_WH_DOWN);
		put_item(mka_pkg::OP_PRESS, mka_pkg::KEY_DOWN);
		put_item(mka_pkg::OP_CLEAR, 8'hFF);
		put_item(mka_pkg::OP_TICK, 8'h00);
		settle();

		run_phase(mka_pkg::START_DELAY_RST, mka_pkg::REPEAT_INTV_RST, mka_pkg::SPEEDUP_RST,
			mka_pkg::SPEED_CAP_RST, 300, 1'b1, 1'b0);
		run_phase(8'd0, 8'd0, 8'd0, 7'd127, 250, 1'b1, 1'b1);
		run_phase(8'd3, 8'd2, 8'd1, 7'd0, 150, 1'b1, 1'b0);
		run_phase(8'd255, 8'd255, 8'd255, 7'd1, 200, 1'b1, 1'b0);
		run_phase(8'd10, 8'd3, 8'd4, 7'd7, 300, 1'b1, 1'b0);
		run_phase(8'd1, 8'd1, 8'd2, 7'd64, 300, 1'b0, 1'b0);

		$display("Covered %0d item beats over seven register settings, including a long sink hold",
			board.beats);
		$display("Checked %0d reports, %0d of them carrying wheel motion",
			board.reports, board.wheel_reports);
		if (board.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
